/* rtl/matu_pkg.sv */
package matu_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = 2;
    localparam int CELLS     = DIM * DIM;
    localparam int CELL_BITS = 2 * IDX_BITS;
    localparam int PROD_BITS = 2 * WORD_BITS;
    // four shifted products of at most 2^46 each, plus sign
    localparam int ACC_BITS  = WORD_BITS + FRAC_BITS + 2;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        FN_LOAD_A = 3'd0,
        FN_LOAD_B = 3'd1,
        FN_ADD    = 3'd2,
        FN_SUB    = 3'd3,
        FN_MUL    = 3'd4,
        FN_SCALE  = 3'd5
    } t_func;

    typedef logic [CELL_BITS-1:0] t_cell;

    typedef struct packed {
        logic  load_a;
        logic  load_b;
        logic  start;
        logic  mul;
        logic  acc;
        logic  clr;
        logic  emit;
        logic  last;
        logic  flip;
        t_func op;
        t_cell a_idx;
        t_cell b_idx;
        t_cell pos;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/matu_if.sv */
interface matu_in_if;
    import matu_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  func;
    logic [IDX_BITS-1:0]         row;
    logic [IDX_BITS-1:0]         col;
    logic signed [WORD_BITS-1:0] value;

    modport source (output valid, func, row, col, value, input ready);
    modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface matu_out_if;
    import matu_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [IDX_BITS-1:0]         out_row;
    logic [IDX_BITS-1:0]         out_col;
    logic signed [WORD_BITS-1:0] element;
    logic                        saturated;
    logic                        last;

    modport source (output valid, out_row, out_col, element, saturated, last, input ready);
    modport sink   (input valid, out_row, out_col, element, saturated, last, output ready);
endinterface

/* rtl/matrix4x4_arithmetic_unit_core.sv */
// 4x4 Q16.16 matrix unit: accumulator A and operand B, both zero after reset.
// Input channel i_in carries func, row, col and value. Loads (func 0 and 1)
// write one element of A or B; codes 6 and 7 are dropped.
// Operations (add, subtract, multiply, scale) rewrite A and send all 16 new
// elements on o_out in row-major order, last set on the final beat, with
// saturated set where the element was clipped.
// Each element runs through one shared 32x32 multiplier / adder and one
// accumulator: each term passes S_MUL then S_ACC, and S_SAT saturates the
// sum. Add, subtract and scale use one term per element; multiply sums
// four terms. i_in.ready is high only while no operation runs.
// A stalled receiver holds the output register and the element sequencer
// waits on it; after the last beat is registered new items are accepted even
// if that beat is not yet taken. Synchronous reset clears both matrices, the
// sequencer and the output valid.
module matrix4x4_arithmetic_unit_core
    import matu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    matu_in_if.sink     i_in,
    matu_out_if.source  o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    matu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    matu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_value     (i_in.value),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_element   (o_out.element),
        .o_saturated (o_out.saturated),
        .o_last      (o_out.last)
    );

endmodule

/* rtl/matu_ctrl.sv */
module matu_ctrl
    import matu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [2:0]          i_in_func,
    output logic                o_in_ready,
    input  t_stat               i_stat,
    output t_cmd                o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_SAT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    t_cell               r_cell, n_cell;
    logic [IDX_BITS-1:0] r_k, n_k;
    t_func               r_op, n_op;
    logic                w_accept;
    logic [IDX_BITS-1:0] w_last_k;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last_k   = (r_op == FN_MUL) ? IDX_BITS'(DIM - 1) : '0;

    always_comb begin
        n_state = r_state;
        n_cell  = r_cell;
        n_k     = r_k;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op  = r_op;
        o_cmd.pos = r_cell;
        if (r_op == FN_MUL) begin
            o_cmd.a_idx = {r_cell[CELL_BITS-1:IDX_BITS], r_k};
            o_cmd.b_idx = {r_k, r_cell[IDX_BITS-1:0]};
        end else begin
            o_cmd.a_idx = r_cell;
            o_cmd.b_idx = r_cell;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_func)
                        FN_LOAD_A: o_cmd.load_a = 1'b1;
                        FN_LOAD_B: o_cmd.load_b = 1'b1;
                        FN_ADD, FN_SUB, FN_MUL, FN_SCALE: begin
                            o_cmd.start = 1'b1;
                            n_op    = t_func'(i_in_func);
                            n_cell  = '0;
                            n_k     = '0;
                            n_state = S_MUL;
                        end
                        default: ; // unused codes: drop the beat
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                o_cmd.clr = (r_k == '0);
                if (r_k == w_last_k) begin
                    n_state = S_SAT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_SAT: begin
                // hold until the output register can take the element
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_cell == t_cell'(CELLS - 1)) begin
                        o_cmd.last = 1'b1;
                        o_cmd.flip = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_cell  = r_cell + 1'b1;
                        n_k     = '0;
                        n_state = S_MUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cell  <= '0;
            r_k     <= '0;
            r_op    <= FN_ADD;
        end else begin
            r_state <= n_state;
            r_cell  <= n_cell;
            r_k     <= n_k;
            r_op    <= n_op;
        end
    end

endmodule

/* rtl/matu_dpath.sv */
module matu_dpath
    import matu_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  logic [IDX_BITS-1:0]         i_row,
    input  logic [IDX_BITS-1:0]         i_col,
    input  logic signed [WORD_BITS-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [IDX_BITS-1:0]         o_out_row,
    output logic [IDX_BITS-1:0]         o_out_col,
    output logic signed [WORD_BITS-1:0] o_element,
    output logic                        o_saturated,
    output logic                        o_last
);

    // two banks of A: an operation reads the live bank and writes the other
    logic signed [WORD_BITS-1:0] r_a [2][CELLS];
    logic signed [WORD_BITS-1:0] r_b [CELLS];
    logic                        r_bank;
    logic signed [WORD_BITS-1:0] r_scalar;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;

    logic                        r_out_valid;
    logic [IDX_BITS-1:0]         r_out_row;
    logic [IDX_BITS-1:0]         r_out_col;
    logic signed [WORD_BITS-1:0] r_element;
    logic                        r_saturated;
    logic                        r_last;

    logic signed [WORD_BITS-1:0] w_a;
    logic signed [WORD_BITS-1:0] w_b;
    logic signed [WORD_BITS:0]   w_sum;
    logic signed [PROD_BITS-1:0] n_prod;
    logic signed [PROD_BITS-1:0] w_shift;
    logic signed [ACC_BITS-1:0]  w_term;
    logic                        w_in_range;
    logic signed [WORD_BITS-1:0] w_sat_val;
    t_cell                       w_load_idx;

    assign w_load_idx = {i_row, i_col};
    assign w_a = r_a[r_bank][i_cmd.a_idx];
    assign w_b = (i_cmd.op == FN_SCALE) ? r_scalar : r_b[i_cmd.b_idx];

    always_comb begin
        w_sum = '0;
        case (i_cmd.op)
            FN_ADD: begin
                w_sum  = {w_a[WORD_BITS-1], w_a} + {w_b[WORD_BITS-1], w_b};
                n_prod = {{(PROD_BITS-WORD_BITS-1){w_sum[WORD_BITS]}}, w_sum};
            end
            FN_SUB: begin
                w_sum  = {w_a[WORD_BITS-1], w_a} - {w_b[WORD_BITS-1], w_b};
                n_prod = {{(PROD_BITS-WORD_BITS-1){w_sum[WORD_BITS]}}, w_sum};
            end
            default: n_prod = w_a * w_b;
        endcase
    end

    assign w_shift = ((i_cmd.op == FN_MUL) || (i_cmd.op == FN_SCALE)) ?
                     (r_prod >>> FRAC_BITS) : r_prod;
    assign w_term  = w_shift[ACC_BITS-1:0];

    // in range when every bit above the word's sign bit matches it
    assign w_in_range = (&r_acc[ACC_BITS-1:WORD_BITS-1]) || !(|r_acc[ACC_BITS-1:WORD_BITS-1]);
    assign w_sat_val  = w_in_range ? r_acc[WORD_BITS-1:0] :
                        (r_acc[ACC_BITS-1] ? WORD_MIN : WORD_MAX);

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CELLS; c++) begin
                r_a[0][c] <= '0;
                r_a[1][c] <= '0;
                r_b[c]    <= '0;
            end
            r_bank <= 1'b0;
        end else begin
            if (i_cmd.load_a) begin
                r_a[r_bank][w_load_idx] <= i_value;
            end
            if (i_cmd.load_b) begin
                r_b[w_load_idx] <= i_value;
            end
            if (i_cmd.emit) begin
                r_a[!r_bank][i_cmd.pos] <= w_sat_val;
            end
            if (i_cmd.flip) begin
                r_bank <= !r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scalar <= i_value;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc) begin
            r_acc <= (i_cmd.clr ? ACC_BITS'(0) : r_acc) + w_term;
        end
        if (i_cmd.emit) begin
            r_out_row   <= i_cmd.pos[CELL_BITS-1:IDX_BITS];
            r_out_col   <= i_cmd.pos[IDX_BITS-1:0];
            r_element   <= w_sat_val;
            r_saturated <= !w_in_range;
            r_last      <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_element   = r_element;
    assign o_saturated = r_saturated;
    assign o_last      = r_last;

endmodule
